>>> sv/sht_pkg.sv
// Package: code tree ROM and shared constants for the static tree decoder.
package sht_pkg;
  localparam int unsigned NodeCount = 256;
  localparam int unsigned NodeW = 8;
  localparam int unsigned ByteW = 8;
  localparam logic signed [9:0] FlushLeaf = -10'sd256;

  typedef logic signed [9:0] child_t;

  localparam child_t TreeOne [NodeCount] = '{
    1,3,5,6,8,10,12,-256,15,17,19,21,-1,24,26,28,
    30,32,34,36,38,40,41,43,-6,46,48,50,-119,-32,54,55,
    56,58,60,61,63,65,67,69,71,-51,74,76,-101,-4,78,-110,
    81,82,84,85,87,89,-15,91,-21,-117,95,97,99,-114,-105,-26,
    104,106,108,110,112,113,114,115,116,-20,119,121,123,125,127,129,
    130,131,133,-120,136,137,-109,139,141,143,-112,-19,147,149,150,-13,
    151,153,-30,156,-99,159,161,-23,-29,-11,166,167,169,-16,-34,173,
    174,175,176,177,-17,-28,179,181,183,185,187,188,189,-79,-59,190,
    -83,191,-67,-98,-12,194,-55,-24,-70,-94,197,-74,-82,-56,-44,-248,
    -163,-52,202,-48,-122,203,-54,-86,205,207,-53,-133,209,211,212,-106,
    214,216,218,219,221,223,225,227,-160,-46,-127,-103,232,-60,235,236,
    237,-149,239,-35,-71,-69,-89,-62,-75,-72,-63,242,-150,-139,-126,-142,
    -138,-240,-204,-152,-227,-154,-153,-176,-165,-172,-195,-232,-219,-200,-175,-244,
    -246,-203,-202,-173,-184,-193,-199,-190,-230,-169,-191,-47,244,246,-148,248,
    -92,-96,-151,250,-241,-161,253,-135,-187,255,-162,-242,-43,-215,-140,-137,
    -158,-136,-155,-228,-213,-224,-196,-183,-231,-174,-252,-198,-188,-223,-180,-245
  };

  localparam child_t TreeZero [NodeCount] = '{
    2,4,0,7,9,11,13,14,16,18,20,22,23,25,27,29,
    31,33,35,37,39,-64,42,44,45,47,49,51,52,53,-14,-5,
    57,59,-2,62,64,66,68,70,72,73,75,77,-111,-97,79,80,
    -116,83,-255,86,88,90,-10,92,93,94,96,98,100,101,102,103,
    105,107,109,111,-3,-7,-131,-144,117,118,120,122,124,126,128,-100,
    -8,132,134,135,-31,138,-234,140,142,144,145,146,148,-66,-145,-65,
    152,154,155,157,158,160,162,163,164,165,-115,168,170,171,172,-132,
    -108,-22,-9,-84,-37,178,180,182,184,186,-104,-78,-61,-178,-134,-25,
    -18,-57,192,193,-68,195,-128,-50,196,-33,-129,198,199,-87,200,201,
    -81,-123,-113,-41,-40,-90,204,-192,206,-130,208,-45,210,-91,213,-88,
    215,217,-49,220,222,224,226,-102,228,229,230,231,233,234,-76,-121,
    -73,238,-107,240,-27,241,-77,-118,-85,-58,-80,-42,-157,-236,-243,-214,
    -206,-146,-147,-201,-207,-209,-254,-156,-210,-185,-170,-211,-239,-177,-212,-143,
    -171,-221,-181,-250,-164,-218,-220,-249,-217,-216,-197,243,245,247,-159,249,
    -93,-225,-95,251,252,-36,254,-39,-124,-251,-238,-38,-125,-253,-208,-235,
    -237,-205,-141,-229,-168,-194,-226,-233,-167,-189,-166,-222,-179,-182,-186,-247
  };
endpackage

>>> sv/sht_stream_if.sv
// Interfaces: valid/ready channels for compressed and decoded bytes.
interface sht_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface sht_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

>>> sv/static_huffman_tree_decoder.sv
// Static code tree decoder: one code bit per stall-free cycle from a synchronous tree ROM.
// Flow: a byte is accepted in idle and walked one bit per cycle while the output is free,
// over its 8 bits or until a flush code ends it; the done state then releases the held
// result, and only after it is the next byte accepted.
// Output: a decoded byte is held until the next leaf or the end of its byte decides last,
// and is on the output in the next cycle; the walk stalls while the output register is full.
// Reset (async, active low) returns the walk to the root, no bits pending, output empty.
module static_huffman_tree_decoder (
  input logic clk_i,
  input logic rst_ni,
  sht_in_if.sink   in_if,
  sht_out_if.source out_if
);
  import sht_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;
  logic [NodeW-1:0] node_q, node_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [3:0] used_q, used_d;
  logic pend_q, pend_d;
  logic [ByteW-1:0] pbyte_q, pbyte_d;
  logic ovalid_q, ovalid_d;
  logic [ByteW-1:0] obyte_q, obyte_d;
  logic olast_q, olast_d;
  child_t one_q, zero_q;
  child_t child, neg_child;
  logic out_free;

  // ROM read: address is the node the next step starts from
  always_ff @(posedge clk_i) begin
    one_q  <= TreeOne[node_d];
    zero_q <= TreeZero[node_d];
  end

  assign out_free = !ovalid_q || out_if.ready;
  assign child = shift_q[ByteW-1] ? one_q : zero_q;
  assign neg_child = -child;
  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = ovalid_q;
  assign out_if.out_byte = obyte_q;
  assign out_if.last = olast_q;

  always_comb begin
    state_d = state_q; node_d = node_q; shift_d = shift_q; used_d = used_q;
    pend_d = pend_q; pbyte_d = pbyte_q;
    ovalid_d = ovalid_q && !out_if.ready;
    obyte_d = obyte_q; olast_d = olast_q;
    unique case (state_q)
      StIdle: begin
        if (in_if.valid) begin
          shift_d = in_if.in_byte; used_d = 4'd0; state_d = StWalk;
        end
      end
      StWalk: begin
        // hold the walk while the output register cannot take an item
        if (out_free) begin
          shift_d = {shift_q[ByteW-2:0], 1'b0};
          used_d = used_q + 4'd1;
          if (child > 0) begin
            node_d = child[NodeW-1:0];
          end else begin
            node_d = '0;
            if (child == FlushLeaf) begin
              // drop the rest of the byte
              used_d = 4'd8;
            end else begin
              // a newer leaf shows the held one was not last
              if (pend_q) begin
                ovalid_d = 1'b1; obyte_d = pbyte_q; olast_d = 1'b0;
              end
              pend_d = 1'b1; pbyte_d = neg_child[ByteW-1:0];
            end
          end
          if (used_d == 4'd8) state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          if (pend_q) begin
            ovalid_d = 1'b1; obyte_d = pbyte_q; olast_d = 1'b1;
          end
          pend_d = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; node_q <= '0; shift_q <= '0; used_q <= 4'd8;
      pend_q <= 1'b0; pbyte_q <= '0;
      ovalid_q <= 1'b0; obyte_q <= '0; olast_q <= 1'b0;
    end else begin
      state_q <= state_d; node_q <= node_d; shift_q <= shift_d; used_q <= used_d;
      pend_q <= pend_d; pbyte_q <= pbyte_d;
      ovalid_q <= ovalid_d; obyte_q <= obyte_d; olast_q <= olast_d;
    end
  end
endmodule

>>> tb/tb_sht_checker.sv
// Checker: predicts decoded bytes from accepted input items and compares them with the output.
`timescale 1ns / 100ps
module tb_sht_checker
  import sht_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  sht_in_if         in_if,
  sht_out_if        out_if,
  output int        fail_cnt_o,
  output int        pending_o
);

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } decoded_t;

  decoded_t         decoded_q[$];
  logic [NodeW-1:0] tree_node;

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
    tree_node  = '0;
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_cnt_o++;
  endtask

  // Walk the code tree MSB first; the position carries into the next item.
  function automatic void walk_byte(input logic [ByteW-1:0] code);
    logic [ByteW-1:0] shreg;
    child_t           kid;
    decoded_t         res;
    int               first;
    shreg = code;
    first = decoded_q.size();
    for (int i = 0; i < ByteW; i++) begin
      kid   = shreg[ByteW-1] ? TreeOne[tree_node] : TreeZero[tree_node];
      shreg = shreg << 1;
      if (kid > 0) begin
        tree_node = kid[NodeW-1:0];
      end else begin
        tree_node = '0;
        if (kid == FlushLeaf) break;   // drop the rest of the byte
        kid      = -kid;
        res.data = kid[ByteW-1:0];
        res.last = 1'b0;
        decoded_q.push_back(res);
      end
    end
    if (decoded_q.size() > first) decoded_q[decoded_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    decoded_t exp_res;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (decoded_q.size() == 0) begin
          report($sformatf("unexpected item byte=%0h last=%0b", out_if.out_byte, out_if.last));
        end else begin
          exp_res = decoded_q.pop_front();
          if (out_if.out_byte !== exp_res.data)
            report($sformatf("out_byte %0h, want %0h", out_if.out_byte, exp_res.data));
          if (out_if.last !== exp_res.last)
            report($sformatf("last %0b, want %0b", out_if.last, exp_res.last));
        end
      end
      if (in_if.valid && in_if.ready) walk_byte(in_if.in_byte);
      pending_o = decoded_q.size();
    end
  end

endmodule

>>> tb/tb_static_huffman_tree_decoder.sv
// Testbench top: drives compressed bytes and output stalls, and gives the verdict.
`timescale 1ns / 100ps
module tb_static_huffman_tree_decoder;

  localparam int RandItems = 310;
  localparam int CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   sent_cnt;
  int   cycle_cnt;

  sht_in_if  in_if ();
  sht_out_if out_if ();

  static_huffman_tree_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  tb_sht_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.in_byte <= '0;
    out_if.ready <= 1'b0;
    cycle_cnt    = 0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[static_huffman_tree_decoder] ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] code, input int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= code;
    do @(posedge clk_i); while (!in_if.ready);
    sent_cnt++;
  endtask

  // Output stall: random gaps, plus one long hold while the input keeps coming.
  initial begin
    int  hold;
    bit  pressed;
    hold    = 0;
    pressed = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!pressed && sent_cnt >= 80) begin
        pressed = 1;
        hold    = 300;
      end else if (hold == 0 && $urandom_range(0, 3) == 0) begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] directed [] = '{8'h00, 8'hFF, 8'hD0, 8'hD5, 8'hF8, 8'h80, 8'h01,
                                8'h7F, 8'hAA, 8'h55, 8'hFE, 8'h0F, 8'hF0, 8'hC3,
                                8'h3C, 8'hD0, 8'h00, 8'hFF, 8'hE1, 8'h96};
    bit calm;
    sent_cnt = 0;
    calm = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_byte(directed[i], (i % 3 == 0) ? 0 : pick_gap());
    for (int i = 0; i < RandItems; i++) begin
      // pick per stretch of 40 items between back-to-back items and gappy ones
      if (i % 40 == 0) calm = ($urandom_range(0, 1) == 1);
      send_byte(8'($urandom_range(0, 255)), calm ? 0 : pick_gap());
    end
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[static_huffman_tree_decoder] OK");
    end else begin
      $display("[static_huffman_tree_decoder] ERROR");
    end
    $finish;
  end

endmodule
